// File: src/vft_pkg.sv
`default_nettype none

package vft_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int COORD_BITS_DEF  = 32;

   // widths of the channel fields
   localparam int IN_COORD_BITS = 32;
   localparam int IDX_BITS      = 9;

   localparam logic KIND_CLEAR  = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] vertex_index;
      logic                added;
      logic                full_res;
      logic [IDX_BITS-1:0] stored_count;
   } result_type;

endpackage

`default_nettype wire

// File: src/vft_req_if.sv
`default_nettype none

interface vft_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     kind;
   logic signed [vft_pkg::IN_COORD_BITS-1:0] coord_x;
   logic signed [vft_pkg::IN_COORD_BITS-1:0] coord_y;
   logic signed [vft_pkg::IN_COORD_BITS-1:0] coord_z;

   modport source (output valid, kind, coord_x, coord_y, coord_z, input ready);
   modport sink (input valid, kind, coord_x, coord_y, coord_z, output ready);
endinterface

`default_nettype wire

// File: src/vft_rsp_if.sv
`default_nettype none

interface vft_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vft_pkg::IDX_BITS-1:0]  vertex_index;
   logic                          added;
   logic                          full_res;
   logic [vft_pkg::IDX_BITS-1:0]  stored_count;

   modport source (output valid, vertex_index, added, full_res, stored_count,
                   input ready);
   modport sink (input valid, vertex_index, added, full_res, stored_count,
                 output ready);
endinterface

`default_nettype wire

// File: src/vft_ram.sv
`default_nettype none

module vft_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/vft_ctrl.sv
`default_nettype none

module vft_ctrl #(
   parameter int TABLE_DEPTH = vft_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_BITS  = vft_pkg::COORD_BITS_DEF,
   localparam int KEY_BITS   = (COORD_BITS < vft_pkg::IN_COORD_BITS) ?
                               COORD_BITS : vft_pkg::IN_COORD_BITS,
   localparam int AW         = $clog2(TABLE_DEPTH),
   localparam int CW         = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_kind,
   input  wire logic [vft_pkg::IN_COORD_BITS-1:0]  req_x,
   input  wire logic [vft_pkg::IN_COORD_BITS-1:0]  req_y,
   input  wire logic [vft_pkg::IN_COORD_BITS-1:0]  req_z,
   output logic                                    done_valid,
   input  wire logic                               done_ready,
   output vft_pkg::result_type                     done_fields,
   output logic                                    ram_rd_en,
   output logic      [AW-1:0]                      ram_rd_addr,
   input  wire logic [3*KEY_BITS-1:0]              ram_rd_data,
   output logic                                    ram_wr_en,
   output logic      [AW-1:0]                      ram_wr_addr,
   output logic      [3*KEY_BITS-1:0]              ram_wr_data
);

   localparam int WIDE = (CW > vft_pkg::IDX_BITS) ? CW : vft_pkg::IDX_BITS;

   vft_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       issue_ff, issue_in;
   logic                chk_valid_ff, chk_valid_in;
   logic [AW-1:0]       chk_addr_ff, chk_addr_in;
   logic [3*KEY_BITS-1:0] key_ff, key_in;
   vft_pkg::result_type res_ff, res_in;

   logic more, hit, scan_end, table_full, accept;

   function automatic logic [vft_pkg::IDX_BITS-1:0] to_idx(input logic [CW-1:0] v);
      logic [WIDE-1:0] w;
      w = WIDE'(v);
      return w[vft_pkg::IDX_BITS-1:0];
   endfunction

   assign more       = issue_ff < count_ff;
   assign hit        = chk_valid_ff && (ram_rd_data == key_ff);
   // nothing left in flight and nothing left to read
   assign scan_end   = !chk_valid_ff && !more;
   assign table_full = count_ff == CW'(TABLE_DEPTH);
   assign accept     = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vft_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == vft_pkg::KIND_CLEAR) ?
                          vft_pkg::ST_DONE : vft_pkg::ST_SCAN;
            end
         end
         vft_pkg::ST_SCAN: begin
            if (hit || scan_end) begin
               state_in = vft_pkg::ST_DONE;
            end
         end
         vft_pkg::ST_DONE: begin
            if (done_ready) begin
               state_in = vft_pkg::ST_IDLE;
            end
         end
         default: state_in = vft_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      done_valid = 1'b0;
      ram_rd_en  = 1'b0;
      ram_wr_en  = 1'b0;
      case (state_ff)
         vft_pkg::ST_IDLE: req_ready = 1'b1;
         vft_pkg::ST_SCAN: begin
            ram_rd_en = more;
            ram_wr_en = !hit && scan_end && !table_full;
         end
         vft_pkg::ST_DONE: done_valid = 1'b1;
         default: ;
      endcase
   end

   assign ram_rd_addr = issue_ff[AW-1:0];
   assign ram_wr_addr = count_ff[AW-1:0];
   assign ram_wr_data = key_ff;
   assign done_fields = res_ff;

   // datapath
   always_comb begin
      count_in     = count_ff;
      issue_in     = issue_ff;
      chk_valid_in = chk_valid_ff;
      chk_addr_in  = chk_addr_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      if (accept) begin
         key_in       = {req_x[KEY_BITS-1:0], req_y[KEY_BITS-1:0], req_z[KEY_BITS-1:0]};
         issue_in     = '0;
         chk_valid_in = 1'b0;
         if (req_kind == vft_pkg::KIND_CLEAR) begin
            count_in = '0;
            res_in   = '0;
         end
      end else if (state_ff == vft_pkg::ST_SCAN) begin
         chk_valid_in = more;
         chk_addr_in  = issue_ff[AW-1:0];
         if (more) begin
            issue_in = issue_ff + CW'(1);
         end
         if (hit) begin
            res_in.vertex_index = to_idx(CW'(chk_addr_ff) + CW'(1));
            res_in.added        = 1'b0;
            res_in.full_res     = 1'b0;
            res_in.stored_count = to_idx(count_ff);
         end else if (scan_end) begin
            if (table_full) begin
               res_in.vertex_index = '0;
               res_in.added        = 1'b0;
               res_in.full_res     = 1'b1;
               res_in.stored_count = to_idx(count_ff);
            end else begin
               count_in            = count_ff + CW'(1);
               res_in.vertex_index = to_idx(count_ff + CW'(1));
               res_in.added        = 1'b1;
               res_in.full_res     = 1'b0;
               res_in.stored_count = to_idx(count_ff + CW'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vft_pkg::ST_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
      end
      issue_ff    <= issue_in;
      chk_addr_ff <= chk_addr_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_write_bumps_count: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> count_ff == $past(count_ff) + CW'(1))
      else $error("table write without count increment");

   a_write_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff == vft_pkg::ST_SCAN && !table_full && !chk_valid_ff)
      else $error("table write outside a finished miss");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == vft_pkg::KIND_CLEAR |=>
         count_ff == '0 && state_ff == vft_pkg::ST_DONE)
      else $error("clear transaction did not empty the table");

   a_vertex_scans: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == vft_pkg::KIND_VERTEX |=>
         state_ff == vft_pkg::ST_SCAN && issue_ff == '0 && !chk_valid_ff)
      else $error("vertex transaction did not start a scan");

endmodule

`default_nettype wire

// File: src/vertex_find_or_insert_table.sv
`default_nettype none

// Vertex find-or-insert table. Each vertex transaction (kind 1) is compared
// against the stored vertices, in order, on all three coordinates, taken as raw bit
// patterns in their low COORD_BITS bits; a match returns its 1-based index,
// a miss appends the vertex and returns the new index with added set, and a
// miss on a full table returns index 0 with full_res set. A clear transaction
// (kind 0) empties the table and answers with all fields zero. Vertices live
// in one single-port-read RAM of TABLE_DEPTH entries that is scanned one entry
// per cycle, stopping at the first match or at the stored count; the next
// request is accepted once the result has moved to the output register, even
// if the consumer has not taken it yet. No clearing pass is needed after reset.
module vertex_find_or_insert_table #(
   parameter int TABLE_DEPTH = vft_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_BITS  = vft_pkg::COORD_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   vft_req_if.sink  req,
   vft_rsp_if.source rsp
);

   localparam int KEY_BITS = (COORD_BITS < vft_pkg::IN_COORD_BITS) ?
                             COORD_BITS : vft_pkg::IN_COORD_BITS;
   localparam int AW       = $clog2(TABLE_DEPTH);

   logic                  done_valid, done_ready;
   vft_pkg::result_type   done_fields;
   logic                  ram_rd_en, ram_wr_en;
   logic [AW-1:0]         ram_rd_addr, ram_wr_addr;
   logic [3*KEY_BITS-1:0] ram_rd_data, ram_wr_data;

   logic                  out_valid_ff, out_valid_in;
   vft_pkg::result_type   out_ff;

   vft_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .req_kind    (req.kind),
      .req_x       (req.coord_x),
      .req_y       (req.coord_y),
      .req_z       (req.coord_z),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_fields (done_fields),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   vft_ram #(
      .WIDTH (3 * KEY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register frees the controller while a result waits
   assign done_ready = !out_valid_ff || rsp.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (done_valid && done_ready) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (done_valid && done_ready) begin
         out_ff <= done_fields;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.vertex_index = out_ff.vertex_index;
   assign rsp.added        = out_ff.added;
   assign rsp.full_res     = out_ff.full_res;
   assign rsp.stored_count = out_ff.stored_count;

endmodule

`default_nettype wire

// File: test/vertex_table_checker.sv
`timescale 1ns / 1ps

module vertex_table_checker
   import vft_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   vft_req_if   req_mon,
   vft_rsp_if   rsp_mon,
   output int   error_count,
   output int   expected_left
);

   // coordinates are matched on their low COORD_BITS bits only
   localparam logic [IN_COORD_BITS-1:0] COORD_MASK = (COORD_BITS >= IN_COORD_BITS) ?
      {IN_COORD_BITS{1'b1}} : ({IN_COORD_BITS{1'b1}} >> (IN_COORD_BITS - COORD_BITS));

   logic [3*IN_COORD_BITS-1:0] vertex_table [TABLE_DEPTH];
   int                         stored_total = 0;
   int                         mismatches = 0;
   result_type                 result_queue [$];

   function automatic result_type predict_lookup(input logic kind,
                                                 input logic [3*IN_COORD_BITS-1:0] vertex);
      result_type r;
      int         slot;
      r = '0;
      slot = -1;
      if (kind == KIND_CLEAR) begin
         stored_total = 0;
      end else begin
         for (int i = 0; i < stored_total; i++) begin
            if (vertex_table[i] == vertex) begin
               slot = i;
               break;
            end
         end
         if (slot >= 0) begin
            r.vertex_index = IDX_BITS'(slot + 1);
         end else if (stored_total >= TABLE_DEPTH) begin
            r.full_res = 1'b1;
         end else begin
            vertex_table[stored_total] = vertex;
            stored_total++;
            r.vertex_index = IDX_BITS'(stored_total);
            r.added = 1'b1;
         end
      end
      r.stored_count = IDX_BITS'(stored_total);
      return r;
   endfunction

   function automatic int field_mismatch(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         stored_total = 0;
         result_queue.delete();
      end else begin
         // results first: a result at this edge belongs to an earlier transaction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (result_queue.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d/%0d",
                        $time, rsp_mon.vertex_index, rsp_mon.added, rsp_mon.full_res,
                        rsp_mon.stored_count);
               mismatches++;
            end else begin
               want = result_queue.pop_front();
               mismatches += field_mismatch("vertex_index", want.vertex_index,
                                            rsp_mon.vertex_index);
               mismatches += field_mismatch("added", want.added, rsp_mon.added);
               mismatches += field_mismatch("full_res", want.full_res, rsp_mon.full_res);
               mismatches += field_mismatch("stored_count", want.stored_count,
                                            rsp_mon.stored_count);
            end
         end
         if (req_mon.valid && req_mon.ready)
            result_queue.insert(result_queue.size(),
                                predict_lookup(req_mon.kind,
                                               {req_mon.coord_x & COORD_MASK,
                                                req_mon.coord_y & COORD_MASK,
                                                req_mon.coord_z & COORD_MASK}));
      end
      error_count   <= mismatches;
      expected_left <= result_queue.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import vft_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
   localparam int COORD_BITS  = COORD_BITS_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef logic [3*IN_COORD_BITS-1:0] vertex_bits;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   bit         quiet_tail = 1'b0;
   int         error_count;
   int         expected_left;
   int         cycle_count = 0;
   vertex_bits sent_vertices [$];

   vft_req_if req_if ();
   vft_rsp_if rsp_if ();

   vertex_find_or_insert_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .COORD_BITS (COORD_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   vertex_table_checker #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .COORD_BITS (COORD_BITS)
   ) table_watch (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .error_count  (error_count),
      .expected_left(expected_left)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [IN_COORD_BITS-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         4: return {16'($urandom_range(0, 7)) - 16'd3, 16'h0};  // small whole numbers
         5: return {16'h0, 16'($urandom)};                        // pure fractions
         default: return $urandom;
      endcase
   endfunction

   function automatic vertex_bits pick_vertex(input int hit_pct, input int near_pct);
      vertex_bits v;
      int         roll;
      int         lane;
      roll = $urandom_range(0, 99);
      if (sent_vertices.size() != 0 && roll < hit_pct + near_pct) begin
         v = sent_vertices[$urandom_range(0, sent_vertices.size() - 1)];
         if (roll >= hit_pct) begin
            // near miss: one bit of one coordinate flipped
            lane = $urandom_range(0, 2);
            v[lane*IN_COORD_BITS + $urandom_range(0, IN_COORD_BITS - 1)] ^= 1'b1;
         end
      end else begin
         v = {rand_coord(), rand_coord(), rand_coord()};
      end
      return v;
   endfunction

   task automatic send_item(input logic kind, input vertex_bits v);
      bit seen;
      req_if.valid   <= 1'b1;
      req_if.kind    <= kind;
      req_if.coord_x <= v[3*IN_COORD_BITS-1 -: IN_COORD_BITS];
      req_if.coord_y <= v[2*IN_COORD_BITS-1 -: IN_COORD_BITS];
      req_if.coord_z <= v[IN_COORD_BITS-1 -: IN_COORD_BITS];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // mirror of the table contents, used to choose hits and to tell when the table is full
      if (kind == KIND_CLEAR) begin
         sent_vertices.delete();
      end else begin
         seen = 1'b0;
         foreach (sent_vertices[i])
            if (sent_vertices[i] == v) seen = 1'b1;
         if (!seen && sent_vertices.size() < TABLE_DEPTH)
            sent_vertices.insert(sent_vertices.size(), v);
      end
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   initial begin : sink_pacing
      int unsigned run_len;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         run_len = $urandom_range(1, 40);
         repeat (run_len) @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 1) == 1) begin
            rsp_if.ready <= 1'b0;
            run_len = $urandom_range(1, 16);
            repeat (run_len) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      req_if.valid   = 1'b0;
      req_if.kind    = KIND_CLEAR;
      req_if.coord_x = '0;
      req_if.coord_y = '0;
      req_if.coord_z = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, hits, near misses, clears
      send_item(KIND_CLEAR,  {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
      send_item(KIND_VERTEX, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
      send_item(KIND_VERTEX, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
      send_item(KIND_VERTEX, {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
      send_item(KIND_VERTEX, {32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      send_item(KIND_VERTEX, {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
      send_item(KIND_VERTEX, {32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000});
      send_item(KIND_VERTEX, {32'h0000_0000, 32'h0000_0000, 32'h0000_0001});
      send_item(KIND_VERTEX, {32'h0000_0000, 32'h0000_0001, 32'h0000_0000});
      send_item(KIND_VERTEX, {32'h0000_0001, 32'h0000_0000, 32'h0000_0000});
      send_item(KIND_VERTEX, {32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      send_item(KIND_VERTEX, {32'h0001_8000, 32'hfffe_8000, 32'h0000_0001});
      send_item(KIND_CLEAR,  {32'($urandom), 32'($urandom), 32'($urandom)});
      send_item(KIND_VERTEX, {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
      send_item(KIND_VERTEX, {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
      send_item(KIND_CLEAR,  {32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
      send_item(KIND_CLEAR,  {32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
      wait_all_results();

      // mixed hits, misses and the odd clear on a partly filled table
      repeat (60)
         send_item(($urandom_range(0, 24) == 0) ? KIND_CLEAR : KIND_VERTEX,
                   pick_vertex(45, 15));
      wait_all_results();

      // fill the table, then keep hitting it and overflowing it
      send_item(KIND_CLEAR, pick_vertex(0, 0));
      while (sent_vertices.size() < TABLE_DEPTH)
         send_item(KIND_VERTEX, pick_vertex(10, 10));
      repeat (40) send_item(KIND_VERTEX, pick_vertex(50, 20));
      wait_all_results();

      // back to back on both sides
      quiet_tail = 1'b1;
      send_item(KIND_CLEAR, pick_vertex(0, 0));
      repeat (60)
         send_item(($urandom_range(0, 29) == 0) ? KIND_CLEAR : KIND_VERTEX,
                   pick_vertex(40, 20));
      wait_all_results();
      repeat (TABLE_DEPTH + 8) @(posedge clock);

      if (error_count == 0 && expected_left == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
